// File: sv/scts_pkg.sv
// ----------------------------------------------------------------------------
// scts_pkg
// Shared types and constants for the sharded completion tracker.
// ----------------------------------------------------------------------------
package scts_pkg;

    // Field widths fixed by the stream format
    localparam int OP_W     = 2;
    localparam int CTX_W    = 4;
    localparam int ACT_W    = 5;
    localparam int ERR_W    = 2;
    // Contexts addressable through a CTX_W-bit field
    localparam int CTX_SPAN = 2 ** CTX_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TRACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_MIG    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNF = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVF = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_RD_DST   = 5'b00100,
        S_EXEC_MIG = 5'b01000,
        S_WR_DST   = 5'b10000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // capture transaction, read source counter
        logic rd_dst;    // read destination counter, hold source counter
        logic exec_sf;   // execute track / finish / ignored item, load result
        logic exec_mig;  // execute migrate, write source, load result
        logic wr_dst;    // write destination counter of a migrate
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_mig;    // incoming transaction is a real migrate
        logic out_free;  // result register can take a new result
    } status_t;

endpackage

// File: sv/scts_ctrl.sv
// ----------------------------------------------------------------------------
// scts_ctrl
// Sequencer: steps each transaction through read, execute and write-back.
// ----------------------------------------------------------------------------
module scts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  scts_pkg::status_t status,
    output scts_pkg::cmd_t   cmd
);
    import scts_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.in_mig ? S_RD_DST : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec_sf = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RD_DST:
            begin
                cmd.rd_dst = 1'b1;
                state_next = S_EXEC_MIG;
            end
            S_EXEC_MIG:
            begin
                if (status.out_free)
                begin
                    cmd.exec_mig = 1'b1;
                    state_next   = S_WR_DST;
                end
            end
            S_WR_DST:
            begin
                cmd.wr_dst = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/scts_datapath.sv
// ----------------------------------------------------------------------------
// scts_datapath
// Counter memory, active-context count, update logic and result register.
// ----------------------------------------------------------------------------
module scts_datapath #(
    parameter int NUM_CONTEXTS = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [scts_pkg::OP_W-1:0]     in_op,
    input  logic [scts_pkg::CTX_W-1:0]    in_src,
    input  logic [scts_pkg::CTX_W-1:0]    in_dst,
    input  scts_pkg::cmd_t                cmd,
    output scts_pkg::status_t             status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_fire,
    output logic [scts_pkg::ACT_W-1:0]    out_active,
    output logic [scts_pkg::ERR_W-1:0]    out_err
);
    import scts_pkg::*;

    localparam int MEM_DEPTH = (NUM_CONTEXTS < CTX_SPAN) ? NUM_CONTEXTS : CTX_SPAN;
    localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Captured transaction
    logic [OP_W-1:0]       op_reg;
    logic [IDX_W-1:0]      src_idx_reg;
    logic [IDX_W-1:0]      dst_idx_reg;
    logic                  ign_reg;

    // Counter store
    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [COUNT_BITS-1:0] src_cnt_reg;
    logic [COUNT_BITS-1:0] dst_wdata_reg;
    logic [COUNT_BITS-1:0] dst_wdata_next;
    logic                  mig_ok_reg;
    logic                  mig_ok_next;

    logic [IDX_W-1:0]      addr;
    logic                  we;
    logic                  re;
    logic [COUNT_BITS-1:0] wdata;

    logic [ACT_W-1:0]      active_reg;
    logic [ACT_W-1:0]      active_next;
    logic                  fire;
    logic [ERR_W-1:0]      err;
    logic                  load_out;

    logic                  out_valid_reg;
    logic                  out_fire_reg;
    logic [ACT_W-1:0]      out_active_reg;
    logic [ERR_W-1:0]      out_err_reg;

    // Decode of the incoming transaction
    logic in_src_ok;
    logic in_dst_ok;
    logic in_ign;
    always_comb
    begin
        in_src_ok = 32'(in_src) < 32'(NUM_CONTEXTS);
        in_dst_ok = 32'(in_dst) < 32'(NUM_CONTEXTS);
        in_ign    = (in_op == OP_NONE) || !in_src_ok ||
                    ((in_op == OP_MIG) && (!in_dst_ok || (in_src == in_dst)));
        status.in_mig   = (in_op == OP_MIG) && !in_ign;
        status.out_free = !out_valid_reg || out_ready;
    end

    // Capture registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= in_op;
            src_idx_reg <= IDX_W'(in_src);
            dst_idx_reg <= IDX_W'(in_dst);
            ign_reg     <= in_ign;
        end
        if (cmd.rd_dst)
        begin
            src_cnt_reg <= rdata_reg;
        end
        if (cmd.exec_mig)
        begin
            dst_wdata_reg <= dst_wdata_next;
        end
    end

    // Single port address select
    assign re   = cmd.accept || cmd.rd_dst;
    assign addr = cmd.accept ? IDX_W'(in_src) :
                  (cmd.rd_dst || cmd.wr_dst) ? dst_idx_reg : src_idx_reg;

    // Counter memory, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // Update logic
    always_comb
    begin
        we             = 1'b0;
        wdata          = rdata_reg;
        active_next    = active_reg;
        fire           = 1'b0;
        err            = ERR_OK;
        mig_ok_next    = mig_ok_reg;
        dst_wdata_next = dst_wdata_reg;

        if (cmd.exec_sf && !ign_reg)
        begin
            unique case (op_reg)
                OP_TRACK:
                begin
                    if (rdata_reg == CNT_MAX)
                    begin
                        err = ERR_OVF;
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = rdata_reg + CNT_ONE;
                        if (rdata_reg == '0)
                        begin
                            active_next = active_reg + ACT_W'(1);
                        end
                    end
                end
                OP_FINISH:
                begin
                    if (rdata_reg == '0)
                    begin
                        err = ERR_UNF;
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = rdata_reg - CNT_ONE;
                        if ((rdata_reg == CNT_ONE) && (active_reg != '0))
                        begin
                            active_next = active_reg - ACT_W'(1);
                            fire        = (active_reg == ACT_W'(1));
                        end
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end

        // Migrate: source count held, destination count just read
        if (cmd.exec_mig)
        begin
            mig_ok_next = 1'b0;
            if (src_cnt_reg == '0)
            begin
                err = ERR_UNF;
            end
            else if (rdata_reg == CNT_MAX)
            begin
                err = ERR_OVF;
            end
            else
            begin
                we             = 1'b1;
                wdata          = src_cnt_reg - CNT_ONE;
                dst_wdata_next = rdata_reg + CNT_ONE;
                mig_ok_next    = 1'b1;
                if ((rdata_reg == '0) && (src_cnt_reg != CNT_ONE))
                begin
                    active_next = active_reg + ACT_W'(1);
                end
                else if ((rdata_reg != '0) && (src_cnt_reg == CNT_ONE) &&
                         (active_reg != '0))
                begin
                    active_next = active_reg - ACT_W'(1);
                end
            end
        end

        if (cmd.wr_dst && mig_ok_reg)
        begin
            we    = 1'b1;
            wdata = dst_wdata_reg;
        end
    end

    assign load_out = cmd.exec_sf || cmd.exec_mig;

    // Control state: active count, migrate flag, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            mig_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            mig_ok_reg <= mig_ok_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_fire_reg   <= fire;
            out_active_reg <= active_next;
            out_err_reg    <= err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_fire   = out_fire_reg;
    assign out_active = out_active_reg;
    assign out_err    = out_err_reg;

endmodule

// File: sv/sharded_completion_tracker.sv
// ----------------------------------------------------------------------------
// sharded_completion_tracker
// Counts pending tasks per context and the number of active contexts.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  s_*     | in  | op[1:0], src_context[5:2], dst_context[9:6], zero[15:10]
//  m_*     | out | trigger_fire[0], active_contexts[5:1], error_code[7:6]
//
// Migrate adds a destination read and a write-back to the execute step,
// since both counters pass through the single port of the counter memory.
// One result per transaction; a stalled result holds the execute step,
// the next transaction is taken while a result waits.
// Reset (rst_n low, async) empties all counters at once through valid bits.
// ----------------------------------------------------------------------------
module sharded_completion_tracker #(
    parameter int NUM_CONTEXTS = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op, src_context, dst_context
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // trigger_fire, active_contexts, error_code
);
    import scts_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic             out_fire;
    logic [ACT_W-1:0] out_active;
    logic [ERR_W-1:0] out_err;

    // Sequencer
    scts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    scts_datapath #(
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (s_tdata[1:0]),
        .in_src     (s_tdata[5:2]),
        .in_dst     (s_tdata[9:6]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_fire   (out_fire),
        .out_active (out_active),
        .out_err    (out_err)
    );

    // Result packing
    assign m_tdata = {out_err, out_active, out_fire};

endmodule

// File: sv/scts_checker.sv
// ----------------------------------------------------------------------------
// scts_checker
// Port-level checks for the sharded completion tracker, bound to the top.
// ----------------------------------------------------------------------------
module scts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Ready drops after every accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready high right after accept");

    // Firing means no context left and no error
    a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[5:1] == 5'd0) && (m_tdata[7:6] == 2'd0))
        else $error("trigger with active contexts or error");

    // Unused error code never shows
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] != 2'd3)
        else $error("invalid error code");

    // Active count bounded by addressable contexts
    a_active_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:1] <= 5'd16)
        else $error("active count out of range");

endmodule

bind sharded_completion_tracker scts_checker u_scts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tracker_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_check_pkg
// Scoreboard for the completion tracker: keeps its own per-context task
// counts and active-context total, works out the status each accepted
// transaction must return, and checks returned statuses in order.
// ----------------------------------------------------------------------------
package tracker_check_pkg;

    import scts_pkg::*;

    localparam int NUM_CTX = 16;
    localparam int CNT_W   = 16;
    localparam logic [CNT_W-1:0] CNT_FULL = '1;

    // Result word as it leaves the block, bit 0 first: fire, active, error
    typedef struct packed {
        logic [ERR_W-1:0] error_code;
        logic [ACT_W-1:0] active_contexts;
        logic             trigger_fire;
    } track_status_t;

    class tracker_scoreboard;

        logic [CNT_W-1:0] task_count [NUM_CTX];
        logic [ACT_W-1:0] live_contexts;
        track_status_t    due_status [$];
        int unsigned      mismatches;

        function new();
            foreach (task_count[i])
                task_count[i] = '0;
            live_contexts = '0;
            mismatches    = 0;
        endfunction

        function logic [CNT_W-1:0] count_of(int unsigned ctx);
            return task_count[ctx];
        endfunction

        function logic [ACT_W-1:0] live();
            return live_contexts;
        endfunction

        // Apply one task event to the counters and return its status
        function track_status_t apply_event(logic [OP_W-1:0] op,
                                            logic [CTX_W-1:0] src,
                                            logic [CTX_W-1:0] dst);
            track_status_t st;
            logic          left_empty;
            logic          fresh;
            st = '0;
            st.error_code = ERR_OK;
            case (op)
                OP_TRACK:
                begin
                    if (src < NUM_CTX)
                    begin
                        if (task_count[src] == CNT_FULL)
                            st.error_code = ERR_OVF;
                        else
                        begin
                            if (task_count[src] == '0)
                                live_contexts++;
                            task_count[src]++;
                        end
                    end
                end
                OP_FINISH:
                begin
                    if (src < NUM_CTX)
                    begin
                        if (task_count[src] == '0)
                            st.error_code = ERR_UNF;
                        else
                        begin
                            task_count[src]--;
                            if (task_count[src] == '0 && live_contexts != '0)
                            begin
                                live_contexts--;
                                if (live_contexts == '0)
                                    st.trigger_fire = 1'b1;
                            end
                        end
                    end
                end
                OP_MIG:
                begin
                    // same-context move is a silent no-op
                    if (src < NUM_CTX && dst < NUM_CTX && src != dst)
                    begin
                        if (task_count[src] == '0)
                            st.error_code = ERR_UNF;
                        else if (task_count[dst] == CNT_FULL)
                            st.error_code = ERR_OVF;
                        else
                        begin
                            task_count[src]--;
                            task_count[dst]++;
                            left_empty = (task_count[src] == '0);
                            fresh      = (task_count[dst] == 1);
                            if (fresh && !left_empty)
                                live_contexts++;
                            else if (!fresh && left_empty && live_contexts != '0)
                                live_contexts--;
                        end
                    end
                end
                default: ;
            endcase
            st.active_contexts = live_contexts;
            return st;
        endfunction

        // Accepted input transaction: queue the status it must produce
        function void note_input(logic [OP_W-1:0] op, logic [CTX_W-1:0] src,
                                 logic [CTX_W-1:0] dst);
            due_status.push_back(apply_event(op, src, dst));
        endfunction

        // Accepted output transaction: compare with the oldest status due
        function void check_result(logic [7:0] raw);
            track_status_t got;
            track_status_t want;
            got = track_status_t'(raw);
            if (due_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tracker: result 0x%02h with none outstanding", raw);
            end
            else
            begin
                want = due_status.pop_front();
                if (got.trigger_fire    !== want.trigger_fire ||
                    got.active_contexts !== want.active_contexts ||
                    got.error_code      !== want.error_code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tracker: fire %0b/%0b active %0d/%0d err %0d/%0d (exp/act)",
                                 want.trigger_fire, got.trigger_fire,
                                 want.active_contexts, got.active_contexts,
                                 want.error_code, got.error_code);
                end
            end
        endfunction

    endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sharded completion tracker. A directed opener covers
// underflow, same-context and empty-context migrates, unused op codes and
// trigger firing; then random track/finish/migrate sequences over small
// context groups that always drain to zero, with noise mixed in. Input
// bursts and output stalls are random; every status is checked by the
// scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import scts_pkg::*;
    import tracker_check_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // op, src_context, dst_context, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // trigger_fire, active_contexts, error_code

    tracker_scoreboard sb;
    int unsigned       items_sent  = 0;
    int unsigned       burst_left  = 0;
    int unsigned       cycle_count = 0;
    bit                ready_hold  = 1'b0;
    int unsigned       ready_run   = 0;

    sharded_completion_tracker #(
        .NUM_CONTEXTS (NUM_CTX),
        .COUNT_BITS   (CNT_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Output side: alternating ready and stall runs of random length
    always @(negedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_hold = !ready_hold;
            ready_run  = ready_hold ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        ready_run--;
        m_tready <= ready_hold;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Send one transaction; bursts of random length with random gaps between
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CTX_W-1:0] src,
                             input logic [CTX_W-1:0] dst);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, dst, src, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, src, dst);
        items_sent++;
    endtask

    function automatic logic [CTX_W-1:0] any_ctx();
        return CTX_W'($urandom_range(0, NUM_CTX - 1));
    endfunction

    // Work on a small group of contexts, then drain everything to zero
    task automatic run_sequence();
        logic [CTX_W-1:0] grp [4];
        int unsigned      n_ops;
        int unsigned      pick;
        logic [CTX_W-1:0] c;
        foreach (grp[i])
            grp[i] = any_ctx();
        n_ops = $urandom_range(4, 24);
        repeat (n_ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(OP_W'($urandom_range(0, 3)), any_ctx(), any_ctx());
            else if (pick < 50)
                send_item(OP_TRACK, grp[$urandom_range(0, 3)], any_ctx());
            else if (pick < 80)
                send_item(OP_FINISH, grp[$urandom_range(0, 3)], any_ctx());
            else
                send_item(OP_MIG, grp[$urandom_range(0, 3)], grp[$urandom_range(0, 3)]);
        end
        while (sb.live() != 0)
        begin
            do
                c = any_ctx();
            while (sb.count_of(c) == 0);
            if ($urandom_range(0, 4) == 0)
                send_item(OP_MIG, c, any_ctx());
            else
                send_item(OP_FINISH, c, any_ctx());
        end
    endtask

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Main sequence
    initial
    begin
        int unsigned target;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opener
        send_item(OP_FINISH, 4'd0, 4'd0);     // finish on empty context
        send_item(OP_MIG, 4'd0, 4'd15);       // migrate out of empty context
        send_item(OP_MIG, 4'd7, 4'd7);        // same context while empty
        send_item(OP_NONE, 4'd15, 4'd15);     // unused op code
        send_item(OP_TRACK, 4'd0, 4'd15);
        send_item(OP_TRACK, 4'd15, 4'd0);
        send_item(OP_TRACK, 4'd15, 4'd0);
        send_item(OP_MIG, 4'd0, 4'd15);       // source empties, target busy
        send_item(OP_MIG, 4'd15, 4'd15);      // same context while busy
        send_item(OP_MIG, 4'd15, 4'd3);       // target becomes active
        send_item(OP_FINISH, 4'd3, 4'd0);
        send_item(OP_FINISH, 4'd15, 4'd0);
        send_item(OP_FINISH, 4'd15, 4'd0);    // last active context: fire
        send_item(OP_TRACK, 4'd5, 4'd0);
        send_item(OP_MIG, 4'd5, 4'd10);       // empties source, fills target
        send_item(OP_MIG, 4'd10, 4'd5);
        send_item(OP_FINISH, 4'd5, 4'd10);    // fire again
        send_item(OP_FINISH, 4'd5, 4'd10);
        send_item(OP_NONE, 4'd0, 4'd0);
        send_item(OP_TRACK, 4'd15, 4'd15);
        send_item(OP_MIG, 4'd15, 4'd0);       // migrate alone never fires
        send_item(OP_FINISH, 4'd0, 4'd15);

        // random sequences
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
            run_sequence();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.due_status.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
sv/scts_pkg.sv
sv/scts_ctrl.sv
sv/scts_datapath.sv
sv/sharded_completion_tracker.sv
sv/scts_checker.sv
sim/tracker_check_pkg.sv
sim/tb_top.sv
